// File: rtl/ipdc_pkg.sv
// shared types, constants and helpers of the ip-in-ip decapsulator
package ipdc_pkg;

  localparam int HEADER_BYTES_DEF = 60;
  localparam int POS_W   = 6;
  localparam int SUM_W   = 22;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [3:0] IHL_MIN       = 4'd5;
  localparam logic [3:0] IHL_MAX       = 4'd15;
  localparam logic [7:0] TUNNEL_PROTO_DEF = 8'd4;

  localparam logic [POS_W-1:0] IDX_TL_HI = POS_W'(2);
  localparam logic [POS_W-1:0] IDX_TL_LO = POS_W'(3);
  localparam logic [POS_W-1:0] IDX_PROTO = POS_W'(9);
  localparam logic [POS_W-1:0] IDX_CK_HI = POS_W'(10);
  localparam logic [POS_W-1:0] IDX_CK_LO = POS_W'(11);
  localparam logic [POS_W-1:0] IDX_IHL_TL = POS_W'(1);

  localparam logic REG_ENABLE       = 1'b0;
  localparam logic REG_TUNNEL_PROTO = 1'b1;

  typedef enum logic {
    CMD_PASS,
    CMD_FLUSH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       data;
    logic             last;
    logic             dec;
    logic             trunc;
    logic [POS_W-1:0] count;
    logic             modified;
    logic [15:0]      ntl;
    logic [7:0]       proto;
    logic [SUM_W-1:0] sum;
  } cmd_t;

  function automatic logic [3:0] clamp_ihl(input logic [3:0] nib, input logic [3:0] max_w);
    logic [3:0] w;
    w = nib;
    if (w < IHL_MIN) w = IHL_MIN;
    if (w > max_w) w = max_w;
    return w;
  endfunction

endpackage

// File: rtl/ipdc_ram.sv
// generic single-write, single-read ram with registered read
module ipdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 60,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/ipdc_queue.sv
// short command queue between the header parser and the output sequencer
module ipdc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ipdc_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output ipdc_pkg::cmd_t  head,
  output logic            not_empty,
  output logic            full
);

  ipdc_pkg::cmd_t                 entries [ipdc_pkg::Q_DEPTH];
  logic [ipdc_pkg::Q_AW-1:0]      wptr;
  logic [ipdc_pkg::Q_AW-1:0]      rptr;
  logic [ipdc_pkg::Q_AW:0]        fill;

  assign head      = entries[rptr];
  assign not_empty = (fill != '0);
  assign full      = (fill == (ipdc_pkg::Q_AW + 1)'(ipdc_pkg::Q_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

// File: rtl/ipdc_front.sv
// header parser: stores the outer header, tracks lengths and sums, issues commands
module ipdc_front #(
  parameter int HEADER_BYTES = ipdc_pkg::HEADER_BYTES_DEF,
  localparam int AW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,   // data_byte
  input  logic           s_tlast,
  input  logic           cfg_valid,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_data,
  input  logic           q_full,
  output logic           q_push,
  output ipdc_pkg::cmd_t q_cmd,
  input  logic           flush_done,
  output logic           ram_we,
  output logic [AW-1:0]  ram_waddr,
  output logic [7:0]     ram_wdata
);

  localparam logic [3:0] OUTER_MAX_W = 4'(HEADER_BYTES / 4);

  typedef enum logic [1:0] {
    PH_OUTER,
    PH_INNER,
    PH_PASS,
    PH_DATA
  } phase_t;

  phase_t                        phase, phase_next;
  logic [ipdc_pkg::POS_W-1:0]    pos, pos_next;
  logic [3:0]                    olen, olen_next;
  logic [3:0]                    ilen, ilen_next;
  logic [7:0]                    iproto, iproto_next;
  logic [7:0]                    oproto, oproto_next;
  logic [7:0]                    tl_hi, tl_hi_next;
  logic [7:0]                    tl_lo, tl_lo_next;
  logic [15:0]                   ntl, ntl_next;
  logic [ipdc_pkg::SUM_W-1:0]    sum, sum_next;
  logic                          busy, busy_next;
  logic                          enable;
  logic [7:0]                    tproto;

  logic                          accept;
  logic [3:0]                    w;
  logic [ipdc_pkg::POS_W-1:0]    len;
  logic [ipdc_pkg::POS_W-1:0]    pos_inc;
  logic                          match;
  logic                          excluded;

  assign s_tready  = !q_full && !(phase == PH_OUTER && busy);
  assign accept    = s_tvalid && s_tready;
  assign ram_waddr = pos[AW-1:0];
  assign ram_wdata = s_tdata;
  assign pos_inc   = pos + 1'b1;
  assign match     = enable && (oproto == tproto);
  assign excluded  = (pos == ipdc_pkg::IDX_TL_HI) || (pos == ipdc_pkg::IDX_TL_LO) ||
                     (pos == ipdc_pkg::IDX_PROTO) || (pos == ipdc_pkg::IDX_CK_HI) ||
                     (pos == ipdc_pkg::IDX_CK_LO);

  always_comb begin
    phase_next  = phase;
    pos_next    = pos;
    olen_next   = olen;
    ilen_next   = ilen;
    iproto_next = iproto;
    oproto_next = oproto;
    tl_hi_next  = tl_hi;
    tl_lo_next  = tl_lo;
    ntl_next    = ntl;
    sum_next    = sum;
    ram_we      = 1'b0;
    q_push      = 1'b0;
    q_cmd       = '0;
    q_cmd.kind  = ipdc_pkg::CMD_PASS;
    q_cmd.data  = s_tdata;
    q_cmd.last  = s_tlast;
    q_cmd.ntl   = ntl;
    q_cmd.proto = iproto;
    q_cmd.sum   = sum;
    w           = olen;
    len         = {w, 2'b00};

    case (phase)
      PH_OUTER: begin
        w   = (pos == '0) ? ipdc_pkg::clamp_ihl(s_tdata[3:0], OUTER_MAX_W) : olen;
        len = {w, 2'b00};
        if (accept) begin
          olen_next = w;
          ram_we    = 1'b1;
          pos_next  = pos_inc;
          if (pos == ipdc_pkg::IDX_TL_HI) tl_hi_next = s_tdata;
          if (pos == ipdc_pkg::IDX_TL_LO) tl_lo_next = s_tdata;
          if (pos == ipdc_pkg::IDX_PROTO) oproto_next = s_tdata;
          if (!excluded) begin
            if (!pos[0]) sum_next = sum + ipdc_pkg::SUM_W'({s_tdata, 8'h00});
            else         sum_next = sum + ipdc_pkg::SUM_W'(s_tdata);
          end
          if (pos_inc >= len) begin
            q_push      = match ? s_tlast : 1'b1;
            q_cmd.kind  = ipdc_pkg::CMD_FLUSH;
            q_cmd.count = len;
            q_cmd.trunc = match;
            if (match && !s_tlast) begin
              phase_next = PH_INNER;
              pos_next   = '0;
            end else if (!match && !s_tlast) begin
              phase_next = PH_PASS;
            end
          end else if (s_tlast) begin
            q_push      = 1'b1;
            q_cmd.kind  = ipdc_pkg::CMD_FLUSH;
            q_cmd.count = pos_inc;
            q_cmd.trunc = 1'b1;
          end
        end
      end
      PH_INNER: begin
        w   = (pos == '0) ? ipdc_pkg::clamp_ihl(s_tdata[3:0], ipdc_pkg::IHL_MAX) : ilen;
        if (accept) begin
          ilen_next = w;
          pos_next  = pos_inc;
          if (pos == '0) ntl_next = {tl_hi, tl_lo} - {10'd0, w, 2'b00};
          if (pos == ipdc_pkg::IDX_IHL_TL) sum_next = sum + ipdc_pkg::SUM_W'(ntl);
          if (pos == ipdc_pkg::IDX_PROTO) begin
            iproto_next = s_tdata;
            sum_next    = sum + ipdc_pkg::SUM_W'(s_tdata);
          end
          if (pos_inc >= {w, 2'b00}) begin
            q_push         = 1'b1;
            q_cmd.kind     = ipdc_pkg::CMD_FLUSH;
            q_cmd.count    = {olen, 2'b00};
            q_cmd.modified = 1'b1;
            if (!s_tlast) phase_next = PH_DATA;
          end else if (s_tlast) begin
            q_push      = 1'b1;
            q_cmd.kind  = ipdc_pkg::CMD_FLUSH;
            q_cmd.count = {olen, 2'b00};
            q_cmd.trunc = 1'b1;
          end
        end
      end
      PH_PASS, PH_DATA: begin
        if (accept) begin
          q_push    = 1'b1;
          q_cmd.dec = (phase == PH_DATA);
        end
      end
      default: begin
        phase_next = PH_OUTER;
      end
    endcase

    // end of packet: start over
    if (accept && s_tlast) begin
      phase_next  = PH_OUTER;
      pos_next    = '0;
      olen_next   = '0;
      ilen_next   = '0;
      iproto_next = '0;
      sum_next    = '0;
    end

    busy_next = busy;
    if (q_push && q_cmd.kind == ipdc_pkg::CMD_FLUSH) busy_next = 1'b1;
    else if (flush_done) busy_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_OUTER;
      pos    <= '0;
      olen   <= '0;
      ilen   <= '0;
      iproto <= '0;
      sum    <= '0;
      busy   <= 1'b0;
      enable <= 1'b1;
      tproto <= ipdc_pkg::TUNNEL_PROTO_DEF;
    end else begin
      phase  <= phase_next;
      pos    <= pos_next;
      olen   <= olen_next;
      ilen   <= ilen_next;
      iproto <= iproto_next;
      sum    <= sum_next;
      busy   <= busy_next;
      if (cfg_valid) begin
        case (cfg_index)
          ipdc_pkg::REG_ENABLE:       enable <= cfg_data[0];
          ipdc_pkg::REG_TUNNEL_PROTO: tproto <= cfg_data;
          default:                    tproto <= tproto;
        endcase
      end
    end
    oproto <= oproto_next;
    tl_hi  <= tl_hi_next;
    tl_lo  <= tl_lo_next;
    ntl    <= ntl_next;
  end

endmodule

// File: rtl/ipdc_back.sv
// output sequencer: plays header flushes from the store and passes payload beats
module ipdc_back #(
  parameter int HEADER_BYTES = ipdc_pkg::HEADER_BYTES_DEF,
  localparam int AW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  ipdc_pkg::cmd_t head,
  input  logic           q_not_empty,
  output logic           q_pop,
  output logic           flush_done,
  output logic           ram_re,
  output logic [AW-1:0]  ram_raddr,
  input  logic [7:0]     ram_rdata,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,   // out_byte
  output logic           m_tlast,
  output logic [2:0]     m_tuser    // has_data, decapsulated, truncated
);

  logic                        flushing;
  logic [ipdc_pkg::POS_W-1:0]  idx;
  logic [ipdc_pkg::POS_W-1:0]  f_count;
  logic                        f_last;
  logic                        f_trunc;
  logic                        f_mod;
  logic [15:0]                 f_ntl;
  logic [7:0]                  f_proto;
  logic [16:0]                 s1;
  logic [15:0]                 ck;

  logic                        rd_vld;
  logic [ipdc_pkg::POS_W-1:0]  rd_idx;
  logic                        rd_last;
  logic                        rd_end;

  logic                        o_vld;
  logic [7:0]                  o_byte;
  logic                        o_last;
  logic                        o_dec;
  logic                        o_trunc;

  logic                        out_load;
  logic                        slot_move;
  logic                        slot_free;
  logic                        issue;
  logic                        idx_end;
  logic                        pass_pop;
  logic                        flush_start;
  logic [7:0]                  sub_byte;

  assign out_load    = !o_vld || m_tready;
  assign slot_move   = rd_vld && out_load;
  assign slot_free   = !rd_vld || slot_move;
  assign issue       = flushing && slot_free;
  assign idx_end     = (idx == f_count - 1'b1);
  assign pass_pop    = q_not_empty && head.kind == ipdc_pkg::CMD_PASS &&
                       !flushing && !rd_vld && out_load;
  assign flush_start = q_not_empty && head.kind == ipdc_pkg::CMD_FLUSH &&
                       !flushing && !rd_vld;
  assign q_pop       = pass_pop || flush_start;
  assign flush_done  = slot_move && rd_end;
  assign ram_re      = issue;
  assign ram_raddr   = idx[AW-1:0];

  assign m_tvalid = o_vld;
  assign m_tdata  = o_byte;
  assign m_tlast  = o_last;
  assign m_tuser  = {o_trunc, o_dec, 1'b1};

  always_comb begin
    sub_byte = ram_rdata;
    if (f_mod) begin
      case (rd_idx)
        ipdc_pkg::IDX_TL_HI: sub_byte = f_ntl[15:8];
        ipdc_pkg::IDX_TL_LO: sub_byte = f_ntl[7:0];
        ipdc_pkg::IDX_PROTO: sub_byte = f_proto;
        ipdc_pkg::IDX_CK_HI: sub_byte = ck[15:8];
        ipdc_pkg::IDX_CK_LO: sub_byte = ck[7:0];
        default:             sub_byte = ram_rdata;
      endcase
    end
  end

  // two-step end-around carry fold, then complement
  always_ff @(posedge clk) begin
    ck <= ~(s1[15:0] + 16'(s1[16]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flushing <= 1'b0;
      idx      <= '0;
      rd_vld   <= 1'b0;
      o_vld    <= 1'b0;
    end else begin
      if (flush_start) begin
        flushing <= 1'b1;
        idx      <= '0;
        f_count  <= head.count;
        f_last   <= head.last;
        f_trunc  <= head.trunc;
        f_mod    <= head.modified;
        f_ntl    <= head.ntl;
        f_proto  <= head.proto;
        s1       <= 17'(head.sum[15:0]) + 17'(head.sum[ipdc_pkg::SUM_W-1:16]);
      end else if (issue) begin
        idx <= idx + 1'b1;
        if (idx_end) flushing <= 1'b0;
      end

      if (issue) begin
        rd_vld  <= 1'b1;
        rd_idx  <= idx;
        rd_end  <= idx_end;
        rd_last <= f_last && idx_end;
      end else if (slot_move) begin
        rd_vld <= 1'b0;
      end

      if (slot_move) begin
        o_vld   <= 1'b1;
        o_byte  <= sub_byte;
        o_last  <= rd_last;
        o_dec   <= f_mod;
        o_trunc <= f_trunc;
      end else if (pass_pop) begin
        o_vld   <= 1'b1;
        o_byte  <= head.data;
        o_last  <= head.last;
        o_dec   <= head.dec;
        o_trunc <= head.trunc;
      end else if (m_tready) begin
        o_vld <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/ipip_tunnel_decapsulator.sv
// ip-in-ip decapsulator top level: parser, command queue, header store, output sequencer
// payload beats: one byte per cycle unless the queue is full or the output stalls;
// each beat is registered in the command queue, then in the output register
// a header of N bytes replays from the store at one byte per cycle unless the output
// stalls; the next packet's first byte waits until that replay has left the store
// reset: synchronous, clears parser, queue and output state; enable = 1, protocol = 4
module ipip_tunnel_decapsulator #(
  parameter int HEADER_BYTES = ipdc_pkg::HEADER_BYTES_DEF,
  localparam int AW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tlast,
  output logic [2:0] m_tuser,   // has_data, decapsulated, truncated
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic           q_full;
  logic           q_push;
  ipdc_pkg::cmd_t q_cmd;
  logic           q_pop;
  ipdc_pkg::cmd_t q_head;
  logic           q_not_empty;
  logic           flush_done;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;

  assign cfg_ready = 1'b1;

  ipdc_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd),
    .flush_done (flush_done),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  ipdc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  ipdc_ram #(.WIDTH(8), .DEPTH(HEADER_BYTES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ipdc_back #(.HEADER_BYTES(HEADER_BYTES)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .flush_done  (flush_done),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

endmodule

// File: dv/tb_top.sv
// testbench for the ip-in-ip decapsulator: packet stimulus, byte-level prediction and checking
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HDR_MAX        = ipdc_pkg::HEADER_BYTES_DEF;
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_BYTES    = 20;
  localparam int DIR_ROWS       = 12;

  typedef enum logic [1:0] {
    ST_OUTER,
    ST_INNER,
    ST_PASS,
    ST_PAYLOAD
  } parse_st_t;

  typedef enum logic [1:0] {
    FILL_RAND,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  typedef enum logic {
    CHK_PREDICT,
    CHK_ECHO
  } chk_t;

  typedef struct packed {
    logic       wr_cfg;
    logic       en;
    logic [7:0] tun_proto;
    logic [3:0] o_ihl;
    logic [7:0] o_proto;
    logic [3:0] i_ihl;
    logic [7:0] i_proto;
    logic [7:0] pay_len;
    logic [7:0] cut;
    fill_t      fill;
    chk_t       chk;
    logic       echo_trunc;
  } pkt_spec_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       last;
    logic       dec;
    logic       trunc;
  } out_beat_t;

  // wr_cfg en proto | o_ihl o_proto i_ihl i_proto | payload cut | fill check echo_trunc
  localparam pkt_spec_t DIR_TAB [DIR_ROWS] = '{
    // plain tunnel packet under the reset settings
    '{1'b0, 1'b1, 8'd4,   4'd5,  8'd4,   4'd5,  8'd6,   8'd1, 8'd0,  FILL_RAND, CHK_PREDICT, 1'b0},
    // one byte packet, ends inside the outer header
    '{1'b0, 1'b1, 8'd4,   4'd5,  8'd4,   4'd5,  8'd6,   8'd4, 8'd1,  FILL_RAND, CHK_ECHO,    1'b1},
    // short outer ihl, other protocol passes unchanged
    '{1'b0, 1'b1, 8'd4,   4'd0,  8'd17,  4'd5,  8'd6,   8'd2, 8'd21, FILL_RAND, CHK_ECHO,    1'b0},
    // all ones, no match
    '{1'b0, 1'b1, 8'd4,   4'd5,  8'hff,  4'd15, 8'hff,  8'd2, 8'd21, FILL_ONES, CHK_ECHO,    1'b0},
    // all zeros, short inner ihl, total length wraps
    '{1'b0, 1'b1, 8'd4,   4'd0,  8'd4,   4'd0,  8'd0,   8'd0, 8'd0,  FILL_ZERO, CHK_PREDICT, 1'b0},
    // early end in outer header
    '{1'b0, 1'b1, 8'd4,   4'd6,  8'd4,   4'd5,  8'd6,   8'd4, 8'd13, FILL_RAND, CHK_ECHO,    1'b1},
    // early end in inner header
    '{1'b0, 1'b1, 8'd4,   4'd5,  8'd4,   4'd5,  8'd17,  8'd4, 8'd27, FILL_RAND, CHK_PREDICT, 1'b0},
    // packet ends with the inner header
    '{1'b0, 1'b1, 8'd4,   4'd5,  8'd4,   4'd6,  8'd17,  8'd0, 8'd0,  FILL_RAND, CHK_PREDICT, 1'b0},
    // packet ends with the outer header of a tunnel packet
    '{1'b0, 1'b1, 8'd4,   4'd5,  8'd4,   4'd5,  8'd6,   8'd0, 8'd20, FILL_RAND, CHK_ECHO,    1'b1},
    // protocol 255, longest outer header
    '{1'b1, 1'b1, 8'hff,  4'd15, 8'hff,  4'd5,  8'hff,  8'd1, 8'd0,  FILL_ONES, CHK_PREDICT, 1'b0},
    // disabled, tunnel packet passes unchanged
    '{1'b1, 1'b0, 8'd4,   4'd5,  8'd4,   4'd5,  8'd6,   8'd3, 8'd21, FILL_RAND, CHK_ECHO,    1'b0},
    // protocol 0, all zeros
    '{1'b1, 1'b1, 8'd0,   4'd5,  8'd0,   4'd5,  8'd0,   8'd0, 8'd0,  FILL_ZERO, CHK_PREDICT, 1'b0}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [2:0] m_tuser;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'h00;

  int send_idle_pct = 22;
  int recv_idle_pct = 54;
  int err_count = 0;
  int quiet_cycles = 0;

  // predictor state
  logic       cfg_en = 1'b1;
  logic [7:0] cfg_proto = ipdc_pkg::TUNNEL_PROTO_DEF;
  logic [7:0] hdr_mem [0:HDR_MAX-1];
  int         hdr_pos;
  parse_st_t  pst;
  int         o_words;
  int         i_words;
  logic [7:0] i_proto_seen;
  int         word_sum;

  out_beat_t  due_q [$];
  logic [7:0] pkt_bytes [$];

  ipip_tunnel_decapsulator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int ihl_words(input logic [3:0] nib);
    if (nib < ipdc_pkg::IHL_MIN) return ipdc_pkg::IHL_MIN;
    if (nib > HDR_MAX / 4) return HDR_MAX / 4;
    return nib;
  endfunction

  function automatic void restart_packet();
    hdr_pos = 0;
    pst = ST_OUTER;
    o_words = 0;
    i_words = 0;
    i_proto_seen = 8'h00;
    word_sum = 0;
  endfunction

  function automatic void due(input logic [7:0] b, input logic l, input logic d, input logic t);
    out_beat_t e;
    e = '{data: b, has_data: 1'b1, last: l, dec: d, trunc: t};
    due_q.push_back(e);
  endfunction

  function automatic void replay_plain(input int cnt, input logic l, input logic t);
    for (int k = 0; k < cnt && k < HDR_MAX; k++)
      due(hdr_mem[k], l && (k + 1 == cnt), 1'b0, t);
  endfunction

  function automatic void replay_rewritten(input logic l);
    int         len;
    int         s;
    logic [15:0] ntl;
    logic [15:0] ck;
    logic [7:0] b;
    len = o_words * 4;
    ntl = {hdr_mem[ipdc_pkg::IDX_TL_HI], hdr_mem[ipdc_pkg::IDX_TL_LO]} - 16'(i_words * 4);
    s = word_sum + ntl + i_proto_seen;
    while (s > 'hffff) s = (s & 'hffff) + (s >> 16);
    ck = ~s[15:0];
    for (int k = 0; k < len && k < HDR_MAX; k++) begin
      case (k)
        ipdc_pkg::IDX_TL_HI: b = ntl[15:8];
        ipdc_pkg::IDX_TL_LO: b = ntl[7:0];
        ipdc_pkg::IDX_PROTO: b = i_proto_seen;
        ipdc_pkg::IDX_CK_HI: b = ck[15:8];
        ipdc_pkg::IDX_CK_LO: b = ck[7:0];
        default: b = hdr_mem[k];
      endcase
      due(b, l && (k + 1 == len), 1'b1, 1'b0);
    end
  endfunction

  function automatic void track_byte(input logic [7:0] b, input logic l);
    int   len;
    logic hit;
    case (pst)
      ST_OUTER: begin
        if (hdr_pos == 0) o_words = ihl_words(b[3:0]);
        len = o_words * 4;
        if (hdr_pos < HDR_MAX) hdr_mem[hdr_pos] = b;
        // length, protocol and checksum are rebuilt, the rest is summed as is
        if (hdr_pos != ipdc_pkg::IDX_TL_HI && hdr_pos != ipdc_pkg::IDX_TL_LO &&
            hdr_pos != ipdc_pkg::IDX_PROTO && hdr_pos != ipdc_pkg::IDX_CK_HI &&
            hdr_pos != ipdc_pkg::IDX_CK_LO)
          word_sum += (hdr_pos % 2 == 0) ? {b, 8'h00} : {8'h00, b};
        hdr_pos++;
        if (hdr_pos >= len) begin
          hit = cfg_en && (hdr_mem[ipdc_pkg::IDX_PROTO] == cfg_proto);
          if (hit) begin
            if (l) begin
              replay_plain(len, 1'b1, 1'b1);
              restart_packet();
            end else begin
              pst = ST_INNER;
              hdr_pos = 0;
            end
          end else begin
            replay_plain(len, l, 1'b0);
            if (l) restart_packet();
            else pst = ST_PASS;
          end
        end else if (l) begin
          replay_plain(hdr_pos, 1'b1, 1'b1);
          restart_packet();
        end
      end
      ST_INNER: begin
        if (hdr_pos == 0) i_words = ihl_words(b[3:0]);
        if (hdr_pos == ipdc_pkg::IDX_PROTO) i_proto_seen = b;
        hdr_pos++;
        if (hdr_pos >= i_words * 4) begin
          replay_rewritten(l);
          if (l) restart_packet();
          else pst = ST_PAYLOAD;
        end else if (l) begin
          replay_plain(o_words * 4, 1'b1, 1'b1);
          restart_packet();
        end
      end
      default: begin
        due(b, l, pst == ST_PAYLOAD, 1'b0);
        if (l) restart_packet();
      end
    endcase
  endfunction

  function automatic logic [7:0] fill_byte(input fill_t f);
    case (f)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void build_packet(input pkt_spec_t sp);
    int o_len;
    int i_len;
    pkt_bytes.delete();
    o_len = 4 * ihl_words(sp.o_ihl);
    i_len = 4 * ihl_words(sp.i_ihl);
    for (int k = 0; k < o_len + i_len + sp.pay_len; k++)
      pkt_bytes.push_back(fill_byte(sp.fill));
    pkt_bytes[0] = {pkt_bytes[0][7:4], sp.o_ihl};
    pkt_bytes[ipdc_pkg::IDX_PROTO] = sp.o_proto;
    pkt_bytes[o_len] = {pkt_bytes[o_len][7:4], sp.i_ihl};
    pkt_bytes[o_len + ipdc_pkg::IDX_PROTO] = sp.i_proto;
    if (sp.cut != 0)
      while (pkt_bytes.size() > sp.cut) void'(pkt_bytes.pop_back());
  endfunction

  function automatic pkt_spec_t rand_spec();
    pkt_spec_t sp;
    int        r;
    int        o_len;
    int        i_len;
    sp = '0;
    r = $urandom_range(0, 99);
    if (r < 70) sp.o_ihl = 4'd5;
    else if (r < 80) sp.o_ihl = 4'($urandom_range(0, 4));
    else if (r < 90) sp.o_ihl = 4'($urandom_range(6, 7));
    else if (r < 95) sp.o_ihl = 4'd15;
    else sp.o_ihl = 4'($urandom);
    sp.o_proto = ($urandom_range(0, 99) < 70) ? cfg_proto : 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 85) sp.i_ihl = 4'd5;
    else if (r < 92) sp.i_ihl = 4'($urandom_range(0, 4));
    else sp.i_ihl = 4'($urandom);
    sp.i_proto = 8'($urandom);
    sp.pay_len = ($urandom_range(0, 99) < 95) ? 8'($urandom_range(0, 8))
                                               : 8'($urandom_range(9, 40));
    r = $urandom_range(0, 99);
    if (r < 90) sp.fill = FILL_RAND;
    else if (r < 95) sp.fill = FILL_ZERO;
    else sp.fill = FILL_ONES;
    sp.chk = CHK_PREDICT;
    o_len = 4 * ihl_words(sp.o_ihl);
    i_len = 4 * ihl_words(sp.i_ihl);
    r = $urandom_range(0, 99);
    if (r < 70) sp.cut = 8'd0;
    else if (r < 80) sp.cut = 8'($urandom_range(1, o_len));
    else if (r < 92) sp.cut = 8'($urandom_range(o_len + 1, o_len + i_len));
    else sp.cut = 8'($urandom_range(1, o_len + i_len + sp.pay_len));
    return sp;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic l, input chk_t chk,
                           input logic etr);
    int n0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n0 = due_q.size();
    track_byte(b, l);
    if (chk == CHK_ECHO) begin
      while (due_q.size() > n0) void'(due_q.pop_back());
      due(b, l, 1'b0, etr);
    end
  endtask

  task automatic send_packet(input pkt_spec_t sp);
    int n;
    build_packet(sp);
    n = pkt_bytes.size();
    for (int k = 0; k < n; k++)
      send_beat(pkt_bytes[k], k == n - 1, sp.chk, sp.echo_trunc);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == ipdc_pkg::REG_ENABLE) cfg_en = val[0];
    else cfg_proto = val;
  endtask

  task automatic apply_config(input logic en, input logic [7:0] proto);
    logic [6:0] junk;
    junk = 7'($urandom);
    settle();
    // upper bits of the enable write are don't-care
    write_reg(ipdc_pkg::REG_ENABLE, {junk, en});
    write_reg(ipdc_pkg::REG_TUNNEL_PROTO, proto);
    cfg_valid <= 1'b0;
  endtask

  function automatic void flag_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("mismatch: %s", what);
  endfunction

  always @(posedge clk) begin : out_check
    out_beat_t e;
    out_beat_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{data: m_tdata, has_data: m_tuser[0], last: m_tlast,
                dec: m_tuser[1], trunc: m_tuser[2]};
        if (due_q.size() == 0) begin
          flag_mismatch($sformatf("beat with nothing pending: data %02h last %0b user %03b",
                                  m_tdata, m_tlast, m_tuser));
        end else begin
          e = due_q.pop_front();
          if (got !== e)
            flag_mismatch($sformatf(
              "exp data %02h has %0b last %0b dec %0b trunc %0b, got %02h %0b %0b %0b %0b",
              e.data, e.has_data, e.last, e.dec, e.trunc,
              got.data, got.has_data, got.last, got.dec, got.trunc));
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    pkt_spec_t sp;
    int        sent;
    restart_packet();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TAB[r].wr_cfg) apply_config(DIR_TAB[r].en, DIR_TAB[r].tun_proto);
      send_packet(DIR_TAB[r]);
    end

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 54;
        recv_idle_pct = 22;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: apply_config(1'b1, ipdc_pkg::TUNNEL_PROTO_DEF);
        1: apply_config(1'b1, 8'hff);
        default: apply_config(1'b1, 8'($urandom));
      endcase
      sent = 0;
      while (sent < PHASE_BYTES) begin
        sp = rand_spec();
        send_packet(sp);
        sent += pkt_bytes.size();
      end
    end

    settle();
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ipdc_pkg.sv
rtl/ipdc_ram.sv
rtl/ipdc_queue.sv
rtl/ipdc_front.sv
rtl/ipdc_back.sv
rtl/ipip_tunnel_decapsulator.sv
dv/tb_top.sv
